FILE: src/mttd_pkg.sv
// Package for the multichannel Telnet terminal device.
// Transaction payload types, operation and register codes, Telnet filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mttd_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  port;
    logic [31:0] write_data;
    logic [2:0]  channel;
    logic [7:0]  net_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  wire_byte;
    logic        wire_valid;
    logic        byte_kept;
    logic        byte_tossed;
    logic [2:0]  new_channel;
    logic        connect_ok;
    logic        irq;
    logic        last;
  } out_item_t;

  localparam logic [2:0] OP_BUS_RD  = 3'd0;
  localparam logic [2:0] OP_BUS_WR  = 3'd1;
  localparam logic [2:0] OP_NET_IN  = 3'd2;
  localparam logic [2:0] OP_TX_SLOT = 3'd3;
  localparam logic [2:0] OP_CONNECT = 3'd4;
  localparam logic [2:0] OP_DISCON  = 3'd5;
  localparam logic [2:0] OP_TICK    = 3'd6;

  localparam logic [1:0] PORT_CONN   = 2'd0;
  localparam logic [1:0] PORT_SELECT = 2'd1;
  localparam logic [1:0] PORT_DATA   = 2'd2;
  localparam logic [1:0] PORT_CSR    = 2'd3;

  localparam logic [1:0] CSR_RX_LEVEL = 2'd0;
  localparam logic [1:0] CSR_TX_FREE  = 2'd1;
  localparam logic [1:0] CSR_RX_THR   = 2'd2;
  localparam logic [1:0] CSR_TX_THR   = 2'd3;

  localparam logic [7:0] B_CR   = 8'h0D;
  localparam logic [7:0] B_LF   = 8'h0A;
  localparam logic [7:0] B_NUL  = 8'h00;
  localparam logic [7:0] B_IAC  = 8'hFF;
  localparam logic [7:0] B_SB   = 8'hFA;
  localparam logic [7:0] B_WILL = 8'hFB;
  localparam logic [7:0] B_DONT = 8'hFE;
  localparam logic [7:0] B_SE   = 8'hF0;

  localparam logic [31:0] RD_EMPTY = 32'h8000_0000;
  localparam logic [3:0]  ACTIVE_RESET = 4'd8;

  typedef enum logic [2:0] {
    F_START, F_CR, F_IAC, F_CMD, F_SUB1, F_SUB2
  } filt_t;

  typedef struct packed {
    logic  keep;
    filt_t nxt;
  } filt_res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_POP, S_SCAN, S_OUT1, S_OUT2
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic pop;
    logic scan;
    logic second;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic pop_needed;
    logic scan_last;
    logic two;
  } status_t;

  function automatic filt_res_t telnet_filter(filt_t s, logic [7:0] b);
    filt_res_t r;
    filt_t     cs;
    r.keep = 1'b0;
    r.nxt  = F_START;
    cs     = (s == F_CR) ? F_START : s;
    if (!(s == F_CR && b == B_NUL)) begin
      case (cs)
        F_START: begin
          if (b == B_CR) begin
            r.keep = 1'b1;
            r.nxt  = F_CR;
          end else if (b == B_IAC) begin
            r.nxt = F_IAC;
          end else begin
            r.keep = 1'b1;
          end
        end
        F_IAC: begin
          if (b == B_IAC) r.keep = 1'b1;
          else if (b == B_SB) r.nxt = F_SUB1;
          else if (b >= B_WILL && b <= B_DONT) r.nxt = F_CMD;
        end
        F_SUB1: r.nxt = (b == B_IAC) ? F_SUB2 : F_SUB1;
        F_SUB2: r.nxt = (b == B_SE) ? F_START : F_SUB1;
        default: r.nxt = F_START;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/mttd_ctrl.sv
// Controller state machine of the terminal device.
// Sequences capture, execute, FIFO pop, tick scan and result output.
// Depends on mttd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mttd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire mttd_pkg::status_t st,
  output mttd_pkg::cmd_t       cmd
);
  import mttd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.tick) state_nxt = S_SCAN;
        else if (st.pop_needed) state_nxt = S_POP;
        else state_nxt = S_OUT1;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_OUT1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_last) state_nxt = S_OUT1;
      end
      S_OUT1: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = st.two ? S_OUT2 : S_IDLE;
      end
      S_OUT2: begin
        out_valid  = 1'b1;
        cmd.second = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  a_second_follows_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT2 |-> $past(state_r) == S_OUT1 || $past(state_r) == S_OUT2)
    else $error("second result without first");

  a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC && st.tick |=> state_r == S_SCAN)
    else $error("tick did not scan");

endmodule
`default_nettype wire

FILE: src/mttd_dp.sv
// Datapath of the terminal device: per-channel state, FIFO memories,
// Telnet filter, transmit escaper, bus registers and tick scan.
// Depends on mttd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mttd_dp #(
  parameter int CHANNELS   = 8,
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mttd_pkg::in_item_t in_data,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata,
  input  wire mttd_pkg::cmd_t     cmd,
  output mttd_pkg::status_t       st,
  output mttd_pkg::out_item_t     out_data
);
  import mttd_pkg::*;

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW   = $clog2(FIFO_DEPTH);
  localparam int LW   = $clog2(FIFO_DEPTH + 1);
  localparam int PW   = AW + 1;
  localparam int MEMD = CHANNELS << AW;
  localparam logic [LW-1:0] DEPTH_L = LW'(FIFO_DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(FIFO_DEPTH);
  localparam logic [AW-1:0] HEAD_MAX = AW'(FIFO_DEPTH - 1);

  logic                connected_r [CHANNELS];
  logic [LW-1:0]       rx_level_r  [CHANNELS];
  logic [LW-1:0]       tx_level_r  [CHANNELS];
  logic [AW-1:0]       rx_head_r   [CHANNELS];
  logic [AW-1:0]       tx_head_r   [CHANNELS];
  filt_t               filt_r      [CHANNELS];
  logic                esc_r       [CHANNELS];
  logic [15:0]         rx_thr_r    [CHANNELS];
  logic [15:0]         tx_thr_r    [CHANNELS];
  logic [7:0]          dev_sel_r;
  logic [CHANNELS-1:0] pend_r, saved_r, sample_r, map_r;
  logic [3:0]          act_r;
  logic [CW-1:0]       scan_r;
  logic                two_r;
  in_item_t            item_r;
  out_item_t           res1_r, res2_r;

  logic [7:0] rx_mem [MEMD];
  logic [7:0] tx_mem [MEMD];
  logic [7:0] rx_q, tx_q;

  logic [5:0]          in_use;
  logic [4:0]          sel;
  logic [CW-1:0]       ci;
  logic                live, is_tick;
  logic [LW-1:0]       rxl, txl;
  logic [AW-1:0]       rxh, txh, rxh_inc, txh_inc, rx_widx, tx_widx;
  logic [PW-1:0]       rx_sum, tx_sum;
  logic                rx_full, tx_full;
  logic [CHANNELS-1:0] conn_map, map_fin;
  logic                free_found, hit;
  logic [CW-1:0]       free_idx;
  filt_res_t           fres;
  logic rx_push, tx_push, filt_upd, conn_new, conn_drop;
  logic sample_upd, sel_upd, rxt_upd, txt_upd, rx_pop, tx_pop;
  logic                pop_needed, esc_n, pop_two;
  logic [1:0]          csr;
  out_item_t           exec_res, pop_res1, pop_res2, scan_res;

  assign in_use  = ({2'b00, act_r} > 6'(CHANNELS)) ? 6'(CHANNELS) : {2'b00, act_r};
  assign is_tick = (item_r.op == OP_TICK);
  assign sel     = (item_r.op == OP_BUS_RD || item_r.op == OP_BUS_WR) ?
                   dev_sel_r[4:0] : {2'b00, item_r.channel};
  assign csr     = dev_sel_r[6:5];
  assign ci      = is_tick ? scan_r : sel[CW-1:0];
  assign live    = ({1'b0, sel} < in_use) && connected_r[sel[CW-1:0]];

  assign rxl = rx_level_r[ci];
  assign txl = tx_level_r[ci];
  assign rxh = rx_head_r[ci];
  assign txh = tx_head_r[ci];
  assign rx_full = (rxl == DEPTH_L);
  assign tx_full = (txl == DEPTH_L);
  assign rx_sum  = PW'(rxh) + PW'(rxl);
  assign tx_sum  = PW'(txh) + PW'(txl);
  assign rx_widx = (rx_sum >= DEPTH_P) ? AW'(rx_sum - DEPTH_P) : AW'(rx_sum);
  assign tx_widx = (tx_sum >= DEPTH_P) ? AW'(tx_sum - DEPTH_P) : AW'(tx_sum);
  assign rxh_inc = (rxh == HEAD_MAX) ? '0 : rxh + AW'(1);
  assign txh_inc = (txh == HEAD_MAX) ? '0 : txh + AW'(1);
  assign fres    = telnet_filter(filt_r[ci], item_r.net_byte);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      conn_map[i] = connected_r[i] && (6'(i) < in_use);
      if (6'(i) < in_use && !connected_r[i]) begin
        free_found = 1'b1;
        free_idx   = CW'(i);
      end
    end
  end

  assign rx_push    = cmd.exec && item_r.op == OP_NET_IN && live && fres.keep && !rx_full;
  assign filt_upd   = cmd.exec && item_r.op == OP_NET_IN && live;
  assign tx_push    = cmd.exec && item_r.op == OP_BUS_WR && item_r.port == PORT_DATA &&
                      live && !tx_full;
  assign conn_new   = cmd.exec && item_r.op == OP_CONNECT && free_found;
  assign conn_drop  = cmd.exec && item_r.op == OP_DISCON && live;
  assign sample_upd = cmd.exec && item_r.op == OP_BUS_RD && item_r.port == PORT_CONN;
  assign sel_upd    = cmd.exec && item_r.op == OP_BUS_WR && item_r.port == PORT_SELECT;
  assign rxt_upd    = cmd.exec && item_r.op == OP_BUS_WR && item_r.port == PORT_CSR &&
                      live && csr == CSR_RX_THR;
  assign txt_upd    = cmd.exec && item_r.op == OP_BUS_WR && item_r.port == PORT_CSR &&
                      live && csr == CSR_TX_THR;
  assign rx_pop     = cmd.pop && item_r.op == OP_BUS_RD;
  assign tx_pop     = cmd.pop && item_r.op == OP_TX_SLOT;
  assign pop_needed = (item_r.op == OP_BUS_RD && item_r.port == PORT_DATA && live &&
                       rxl != '0) || (item_r.op == OP_TX_SLOT && live && txl != '0);

  always_comb begin
    exec_res      = '0;
    exec_res.last = 1'b1;
    case (item_r.op)
      OP_BUS_RD: begin
        case (item_r.port)
          PORT_CONN:   exec_res.read_data = 32'(conn_map);
          PORT_SELECT: exec_res.read_data = 32'(sample_r);
          PORT_DATA:   if (live && rxl == '0) exec_res.read_data = RD_EMPTY;
          PORT_CSR: begin
            if (live) begin
              case (csr)
                CSR_RX_LEVEL: exec_res.read_data = 32'(rxl);
                CSR_TX_FREE:  exec_res.read_data = 32'(DEPTH_L - txl);
                CSR_RX_THR:   exec_res.read_data = 32'(rx_thr_r[ci]);
                default:      exec_res.read_data = 32'(tx_thr_r[ci]);
              endcase
            end
          end
          default: exec_res.read_data = '0;
        endcase
      end
      OP_NET_IN: begin
        exec_res.byte_kept   = rx_push;
        exec_res.byte_tossed = filt_upd && fres.keep && rx_full;
      end
      OP_CONNECT: begin
        exec_res.new_channel = free_found ? 3'(free_idx) : 3'd0;
        exec_res.connect_ok  = free_found;
      end
      default: exec_res.last = 1'b1;
    endcase
  end

  // FIFO pop results: receive read data and transmit escaper
  always_comb begin
    pop_res1 = '0;
    pop_res2 = '0;
    pop_res2.wire_valid = 1'b1;
    pop_res2.last       = 1'b1;
    pop_res2.wire_byte  = tx_q;
    pop_two  = 1'b0;
    esc_n    = 1'b0;
    if (item_r.op == OP_BUS_RD) begin
      pop_res1.read_data = 32'(rx_q);
    end else begin
      pop_res1.wire_valid = 1'b1;
      pop_res1.wire_byte  = tx_q;
      if (!esc_r[ci]) begin
        esc_n   = (tx_q == B_CR);
        pop_two = (tx_q == B_IAC);
      end else if (tx_q == B_LF) begin
        esc_n = 1'b0;
      end else begin
        esc_n   = (tx_q == B_CR);
        pop_two = 1'b1;
        pop_res1.wire_byte = B_NUL;
      end
    end
    pop_res1.last = !pop_two;
  end

  assign hit = (6'(scan_r) < in_use) && connected_r[scan_r] &&
               ((16'(rxl) > rx_thr_r[ci]) || (16'(DEPTH_L - txl) > tx_thr_r[ci]));
  assign map_fin = map_r | (CHANNELS'(hit) << scan_r);

  always_comb begin
    scan_res      = '0;
    scan_res.irq  = (map_fin != '0);
    scan_res.last = 1'b1;
  end

  assign st.tick       = is_tick;
  assign st.pop_needed = pop_needed;
  assign st.scan_last  = (scan_r == CW'(CHANNELS - 1));
  assign st.two        = two_r;
  assign out_data      = cmd.second ? res2_r : res1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        connected_r[i] <= 1'b0;
        rx_level_r[i]  <= '0;
        tx_level_r[i]  <= '0;
        rx_head_r[i]   <= '0;
        tx_head_r[i]   <= '0;
        filt_r[i]      <= F_START;
        esc_r[i]       <= 1'b0;
        rx_thr_r[i]    <= '0;
        tx_thr_r[i]    <= '0;
      end
      dev_sel_r <= '0;
      pend_r    <= '0;
      saved_r   <= '0;
      sample_r  <= '0;
      map_r     <= '0;
      act_r     <= ACTIVE_RESET;
      scan_r    <= '0;
      two_r     <= 1'b0;
    end else begin
      if (cfg_we) act_r <= cfg_wdata;
      if (sample_upd) sample_r <= saved_r;
      if (sel_upd) dev_sel_r <= item_r.write_data[7:0];
      if (rxt_upd) rx_thr_r[ci] <= item_r.write_data[15:0];
      if (txt_upd) tx_thr_r[ci] <= item_r.write_data[15:0];
      if (filt_upd) filt_r[ci] <= fres.nxt;
      if (rx_push) rx_level_r[ci] <= rxl + LW'(1);
      if (tx_push) tx_level_r[ci] <= txl + LW'(1);
      if (rx_pop) begin
        rx_level_r[ci] <= rxl - LW'(1);
        rx_head_r[ci]  <= rxh_inc;
      end
      if (tx_pop) begin
        tx_level_r[ci] <= txl - LW'(1);
        tx_head_r[ci]  <= txh_inc;
        esc_r[ci]      <= esc_n;
      end
      if (conn_new) begin
        connected_r[free_idx] <= 1'b1;
        rx_level_r[free_idx]  <= '0;
        tx_level_r[free_idx]  <= '0;
        rx_head_r[free_idx]   <= '0;
        tx_head_r[free_idx]   <= '0;
        filt_r[free_idx]      <= F_START;
        esc_r[free_idx]       <= 1'b0;
        pend_r[free_idx]      <= 1'b1;
      end
      if (conn_drop) begin
        connected_r[ci] <= 1'b0;
        pend_r[ci]      <= 1'b1;
      end
      if (cmd.exec) begin
        scan_r <= '0;
        map_r  <= pend_r;
        two_r  <= 1'b0;
      end
      if (cmd.pop) two_r <= pop_two;
      if (cmd.scan) begin
        scan_r <= scan_r + CW'(1);
        map_r  <= map_fin;
        if (st.scan_last) begin
          saved_r <= map_fin;
          pend_r  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.exec) res1_r <= exec_res;
    if (cmd.pop) begin
      res1_r <= pop_res1;
      res2_r <= pop_res2;
    end
    if (cmd.scan && st.scan_last) res1_r <= scan_res;
  end

  always_ff @(posedge clk) begin
    if (rx_push) rx_mem[{ci, rx_widx}] <= item_r.net_byte;
    rx_q <= rx_mem[{ci, rxh}];
  end

  always_ff @(posedge clk) begin
    if (tx_push) tx_mem[{ci, tx_widx}] <= item_r.write_data[7:0];
    tx_q <= tx_mem[{ci, txh}];
  end

endmodule
`default_nettype wire

FILE: src/multichannel_telnet_terminal_device.sv
// Top level of the multichannel Telnet terminal device.
// Joins the controller and the datapath. Depends on mttd_pkg, mttd_ctrl, mttd_dp.
//
// One transaction is handled at a time. Most items pass through accept, execute
// and output register states before the result is offered; an item that pops a
// FIFO adds a pop state for the registered read of the FIFO memory. A tick adds
// a scan state, as the tick scan compares one channel's levels against its
// thresholds per cycle. A transmit slot that emits two wire bytes offers its
// second result in the cycle after the first is taken. The next item is accepted
// the cycle after the last result is taken. No clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_telnet_terminal_device #(
  parameter int CHANNELS   = 8,
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mttd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mttd_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_wdata
);
  import mttd_pkg::*;

  cmd_t    cmd;
  status_t st;

  mttd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  mttd_dp #(
    .CHANNELS   (CHANNELS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the multichannel Telnet terminal device.
// Directed table then random traffic, scored against an in-bench behavioural
// predictor. Depends on mttd_pkg and multichannel_telnet_terminal_device.
`timescale 1ns / 1ps
module testbench;
  import mttd_pkg::*;

  localparam int NCH   = 8;
  localparam int DEPTH = 64;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [3:0] cfg_wdata;

  multichannel_telnet_terminal_device #(.CHANNELS(NCH), .FIFO_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the device state
  bit         conn [NCH];
  logic [7:0] rx_mem [NCH][DEPTH];
  logic [7:0] tx_mem [NCH][DEPTH];
  int         rx_lvl [NCH], tx_lvl [NCH], rx_hd [NCH], tx_hd [NCH];
  filt_t      fstate [NCH];
  bit         after_cr [NCH];
  logic [15:0] rx_thr [NCH], tx_thr [NCH];
  logic [7:0] dev_sel, pend_ev, req_saved, req_sample;
  int         active_cnt;

  out_item_t  exp_results [$];
  int         fails, n_items, n_results, n_cfg, burst_left;

  function automatic int chans_used();
    return active_cnt < NCH ? active_cnt : NCH;
  endfunction

  function automatic bit is_live(int ch);
    return ch < chans_used() && conn[ch];
  endfunction

  function automatic bit telnet_keep(int ch, logic [7:0] b);
    filt_t s;
    s = fstate[ch];
    if (s == F_CR) begin
      if (b == B_NUL) begin
        fstate[ch] = F_START;
        return 1'b0;
      end
      s = F_START;
    end
    case (s)
      F_START: begin
        if (b == B_CR) begin fstate[ch] = F_CR; return 1'b1; end
        if (b == B_IAC) begin fstate[ch] = F_IAC; return 1'b0; end
        fstate[ch] = F_START;
        return 1'b1;
      end
      F_IAC: begin
        if (b == B_IAC) begin fstate[ch] = F_START; return 1'b1; end
        if (b == B_SB) fstate[ch] = F_SUB1;
        else if (b >= B_WILL && b <= B_DONT) fstate[ch] = F_CMD;
        else fstate[ch] = F_START;
        return 1'b0;
      end
      F_SUB1: begin fstate[ch] = (b == B_IAC) ? F_SUB2 : F_SUB1; return 1'b0; end
      F_SUB2: begin fstate[ch] = (b == B_SE) ? F_START : F_SUB1; return 1'b0; end
      default: begin fstate[ch] = F_START; return 1'b0; end
    endcase
  endfunction

  function automatic logic [31:0] bus_result(bit wr, logic [1:0] port, logic [31:0] wd);
    int ch;
    logic [1:0] csr;
    logic [31:0] r;
    ch  = dev_sel[4:0];
    csr = dev_sel[6:5];
    r   = '0;
    if (port == PORT_CONN) begin
      if (wr) return '0;
      req_sample = req_saved;
      for (int i = 0; i < chans_used(); i++) if (conn[i]) r[i] = 1'b1;
      return r;
    end
    if (port == PORT_SELECT) begin
      if (wr) begin dev_sel = wd[7:0]; return '0; end
      return {24'd0, req_sample};
    end
    if (ch >= NCH || !is_live(ch)) return '0;
    if (port == PORT_DATA) begin
      if (wr) begin
        if (tx_lvl[ch] < DEPTH) begin
          tx_mem[ch][(tx_hd[ch] + tx_lvl[ch]) % DEPTH] = wd[7:0];
          tx_lvl[ch]++;
        end
        return '0;
      end
      if (rx_lvl[ch] == 0) return RD_EMPTY;
      r = {24'd0, rx_mem[ch][rx_hd[ch]]};
      rx_hd[ch] = (rx_hd[ch] + 1) % DEPTH;
      rx_lvl[ch]--;
      return r;
    end
    case (csr)
      CSR_RX_LEVEL: return wr ? '0 : rx_lvl[ch];
      CSR_TX_FREE:  return wr ? '0 : DEPTH - tx_lvl[ch];
      CSR_RX_THR: begin
        if (wr) begin rx_thr[ch] = wd[15:0]; return '0; end
        return {16'd0, rx_thr[ch]};
      end
      default: begin
        if (wr) begin tx_thr[ch] = wd[15:0]; return '0; end
        return {16'd0, tx_thr[ch]};
      end
    endcase
  endfunction

  task automatic predict_item(input in_item_t it, output out_item_t res [$]);
    out_item_t r, r2;
    logic [7:0] b, map;
    int ch;
    bit two;
    res = {};
    r = '0;
    r2 = '0;
    r.last = 1'b1;
    two = 1'b0;
    ch = it.channel;
    case (it.op)
      OP_BUS_RD, OP_BUS_WR: r.read_data = bus_result(it.op == OP_BUS_WR, it.port, it.write_data);
      OP_NET_IN: begin
        if (is_live(ch) && telnet_keep(ch, it.net_byte)) begin
          if (rx_lvl[ch] < DEPTH) begin
            rx_mem[ch][(rx_hd[ch] + rx_lvl[ch]) % DEPTH] = it.net_byte;
            rx_lvl[ch]++;
            r.byte_kept = 1'b1;
          end else r.byte_tossed = 1'b1;
        end
      end
      OP_TX_SLOT: begin
        if (is_live(ch) && tx_lvl[ch] > 0) begin
          b = tx_mem[ch][tx_hd[ch]];
          tx_hd[ch] = (tx_hd[ch] + 1) % DEPTH;
          tx_lvl[ch]--;
          r.wire_valid = 1'b1;
          if (!after_cr[ch]) begin
            after_cr[ch] = (b == B_CR);
            two = (b == B_IAC);
            r.wire_byte = b;
            r2.wire_byte = b;
          end else if (b == B_LF) begin
            after_cr[ch] = 1'b0;
            r.wire_byte = b;
          end else begin
            after_cr[ch] = (b == B_CR);
            two = 1'b1;
            r.wire_byte = B_NUL;
            r2.wire_byte = b;
          end
          if (two) begin
            r.last = 1'b0;
            r2.wire_valid = 1'b1;
            r2.last = 1'b1;
          end
        end
      end
      OP_CONNECT: begin
        for (int i = 0; i < chans_used(); i++) begin
          if (!conn[i]) begin
            conn[i] = 1'b1;
            rx_lvl[i] = 0; tx_lvl[i] = 0; rx_hd[i] = 0; tx_hd[i] = 0;
            fstate[i] = F_START; after_cr[i] = 1'b0;
            pend_ev[i] = 1'b1;
            r.new_channel = 3'(i);
            r.connect_ok = 1'b1;
            break;
          end
        end
      end
      OP_DISCON: begin
        if (is_live(ch)) begin
          conn[ch] = 1'b0;
          pend_ev[ch] = 1'b1;
        end
      end
      OP_TICK: begin
        map = pend_ev;
        for (int i = 0; i < chans_used(); i++) begin
          if (conn[i] && (rx_lvl[i] > rx_thr[i] || (DEPTH - tx_lvl[i]) > tx_thr[i]))
            map[i] = 1'b1;
        end
        req_saved = map;
        pend_ev = '0;
        r.irq = (map != 0);
      end
      default: ;
    endcase
    res.push_back(r);
    if (two) res.push_back(r2);
  endtask

  task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      fails++;
    end
  endtask

  task automatic check_result(out_item_t a);
    out_item_t e;
    if (exp_results.size() == 0) begin
      $error("unexpected result transaction 0x%0h", a);
      fails++;
      return;
    end
    e = exp_results.pop_front();
    n_results++;
    cmp_field("read_data", e.read_data, a.read_data);
    cmp_field("wire_byte", e.wire_byte, a.wire_byte);
    cmp_field("wire_valid", e.wire_valid, a.wire_valid);
    cmp_field("byte_kept", e.byte_kept, a.byte_kept);
    cmp_field("byte_tossed", e.byte_tossed, a.byte_tossed);
    cmp_field("new_channel", e.new_channel, a.new_channel);
    cmp_field("connect_ok", e.connect_ok, a.connect_ok);
    cmp_field("irq", e.irq, a.irq);
    cmp_field("last", e.last, a.last);
  endtask

  // result side: stall pattern changes mode periodically
  int stall_mode, rx_cyc;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    rx_cyc++;
    if (rx_cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= (rx_cyc % 4 == 1);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t res [$];
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it, res);
    n_items++;
    if (typed) exp_results.push_back(typed_res);
    else foreach (res[i]) exp_results.push_back(res[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (NCH + 12) @(posedge clk);
  endtask

  task automatic write_active(logic [3:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_cnt = v;
    n_cfg++;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 11))
      0, 1: return B_IAC;
      2: return B_SB;
      3: return 8'($urandom_range(B_WILL, B_DONT));
      4: return B_SE;
      5: return B_CR;
      6: return B_NUL;
      7: return B_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    it.op = OP_BUS_RD;
    it.port = 2'($urandom_range(0, 3));
    it.write_data = $urandom();
    it.channel = 3'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(0, 2));
    it.net_byte = rand_byte();
    pick = $urandom_range(0, 99);
    if (pick < 7) it.op = OP_CONNECT;
    else if (pick < 9) it.op = OP_DISCON;
    else if (pick < 14) it.op = OP_TICK;
    else if (pick < 22) begin
      it.op = OP_BUS_WR;
      it.port = PORT_SELECT;
      it.write_data[4:0] = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(0, 2));
    end else if (pick < 30) begin
      it.op = OP_BUS_WR;
      it.port = PORT_DATA;
      it.write_data[7:0] = rand_byte();
    end else if (pick < 35) begin
      it.op = OP_BUS_WR;
      it.port = PORT_CSR;
      if ($urandom_range(0, 2) != 0) it.write_data[15:0] = 16'($urandom_range(0, 70));
    end else if (pick < 37) begin
      it.op = OP_BUS_WR;
      it.port = PORT_CONN;
    end else if (pick < 50) it.op = OP_BUS_RD;
    else if (pick < 75) it.op = OP_NET_IN;
    else if (pick < 93) it.op = OP_TX_SLOT;
    else it.op = 3'($urandom_range(0, 7));
    return it;
  endfunction

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } row_t;

  row_t dir_tab [$];

  task automatic add_row(logic [2:0] op, logic [1:0] port, logic [31:0] wd,
                         logic [2:0] ch, logic [7:0] nb,
                         bit typed = 1'b0, logic [31:0] rd = '0, bit irq = 1'b0);
    row_t r;
    r.it = '{op: op, port: port, write_data: wd, channel: ch, net_byte: nb};
    r.typed = typed;
    r.res = '0;
    r.res.read_data = rd;
    r.res.irq = irq;
    r.res.last = 1'b1;
    dir_tab.push_back(r);
  endtask

  initial begin
    logic [3:0] cfg_seq [7];
    out_item_t none;
    cfg_seq = '{4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd8, 4'd2};
    none = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    foreach (conn[i]) begin
      conn[i] = 0; rx_lvl[i] = 0; tx_lvl[i] = 0; rx_hd[i] = 0; tx_hd[i] = 0;
      fstate[i] = F_START; after_cr[i] = 0; rx_thr[i] = 0; tx_thr[i] = 0;
    end
    dev_sel = 0; pend_ev = 0; req_saved = 0; req_sample = 0;
    active_cnt = ACTIVE_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(OP_BUS_RD, PORT_CONN, 0, 0, 0, 1, 0);
    add_row(OP_BUS_RD, PORT_SELECT, 0, 0, 0, 1, 0);
    add_row(OP_BUS_RD, PORT_DATA, 0, 0, 0, 1, 0);
    add_row(OP_TICK, 0, 0, 0, 0, 1, 0, 0);
    add_row(OP_CONNECT, 0, 0, 0, 0);
    add_row(OP_BUS_RD, PORT_DATA, 0, 0, 0, 1, RD_EMPTY);
    add_row(OP_NET_IN, 0, 0, 0, 8'h00);
    add_row(OP_NET_IN, 0, 0, 0, B_CR);
    add_row(OP_NET_IN, 0, 0, 0, B_NUL);
    add_row(OP_NET_IN, 0, 0, 0, B_CR);
    add_row(OP_NET_IN, 0, 0, 0, 8'h5A);
    add_row(OP_NET_IN, 0, 0, 0, B_IAC);
    add_row(OP_NET_IN, 0, 0, 0, B_IAC);
    add_row(OP_NET_IN, 0, 0, 0, B_IAC);
    add_row(OP_NET_IN, 0, 0, 0, B_SB);
    add_row(OP_NET_IN, 0, 0, 0, B_IAC);
    add_row(OP_NET_IN, 0, 0, 0, B_SE);
    add_row(OP_NET_IN, 0, 0, 0, B_IAC);
    add_row(OP_NET_IN, 0, 0, 0, B_WILL);
    add_row(OP_NET_IN, 0, 0, 0, 8'h01);
    add_row(OP_TICK, 0, 0, 0, 0, 1, 0, 1);
    add_row(OP_BUS_RD, PORT_CONN, 0, 0, 0, 1, 1);
    add_row(OP_BUS_WR, PORT_DATA, B_CR, 0, 0);
    add_row(OP_BUS_WR, PORT_DATA, B_IAC, 0, 0);
    add_row(OP_BUS_WR, PORT_DATA, B_LF, 0, 0);
    add_row(OP_TX_SLOT, 0, 0, 0, 0);
    add_row(OP_TX_SLOT, 0, 0, 0, 0);
    add_row(OP_TX_SLOT, 0, 0, 0, 0);
    add_row(OP_BUS_WR, PORT_SELECT, 32'h40, 0, 0);
    add_row(OP_BUS_WR, PORT_CSR, 32'hFFFF_FFFF, 7, 8'hFF, 1, 0);
    add_row(OP_BUS_RD, PORT_CSR, 0, 0, 0, 1, 32'hFFFF);
    add_row(OP_DISCON, 0, 0, 0, 0);
    add_row(OP_BUS_WR, PORT_SELECT, 32'hFF, 0, 0);
    add_row(OP_BUS_RD, PORT_DATA, 0, 0, 0, 1, 0);
    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    foreach (cfg_seq[p]) begin
      write_active(cfg_seq[p]);
      repeat (190) send_item(rand_item(), 1'b0, none);
    end
    drain();

    $display("Ran %0d input transactions, %0d results checked, %0d channel-count settings.",
             n_items, n_results, n_cfg);
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/mttd_pkg.sv
src/mttd_ctrl.sv
src/mttd_dp.sv
src/multichannel_telnet_terminal_device.sv
tb/sv/testbench.sv
